@@ hdl/lfs_pkg.sv @@
// shared types, constants and helpers of the line follower steering unit
`default_nettype none

package lfs_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_FILTER_WINDOW = 3'd0;
   localparam logic [2:0] REG_LINE_IS_HIGH  = 3'd1;
   localparam logic [2:0] REG_SEARCH_TICKS  = 3'd2;
   localparam logic [2:0] REG_SEARCH_SPEED  = 3'd3;
   localparam logic [2:0] REG_BASE_SPEED    = 3'd4;
   localparam logic [2:0] REG_TURN_DELTA    = 3'd5;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 15;

   // register reset values
   localparam logic [2:0]  RESET_FILTER_WINDOW = 3'd3;
   localparam logic        RESET_LINE_IS_HIGH  = 1'b1;
   localparam logic [14:0] RESET_SEARCH_TICKS  = 15'd50;
   localparam logic [7:0]  RESET_SEARCH_SPEED  = 8'd120;
   localparam logic [7:0]  RESET_BASE_SPEED    = 8'd150;
   localparam logic [7:0]  RESET_TURN_DELTA    = 8'd60;

   localparam int MAX_WINDOW = 5;
   localparam logic [7:0] SPEED_MAX = 8'd255;

   // remembered turn direction codes
   localparam logic signed [1:0] DIR_LEFT  = 2'sb11;
   localparam logic signed [1:0] DIR_NONE  = 2'sb00;
   localparam logic signed [1:0] DIR_RIGHT = 2'sb01;

   typedef struct packed {
      logic left;
      logic right;
   } sensor_type;

   // window values other than 1, 3 or 5 act as 3
   function automatic logic [2:0] eff_window(input logic [2:0] window);
      logic [2:0] result;
      result = 3'd3;
      if (window == 3'd1 || window == 3'd5) begin
         result = window;
      end
      return result;
   endfunction

   // majority over the first window entries of a history
   function automatic logic majority(input logic [4:0] bits, input logic [2:0] window);
      logic [1:0] count3;
      logic [2:0] count5;
      logic       result;
      count3 = 2'(bits[0]) + 2'(bits[1]) + 2'(bits[2]);
      count5 = 3'(count3) + 3'(bits[3]) + 3'(bits[4]);
      if (window == 3'd1) begin
         result = bits[0];
      end else if (window == 3'd5) begin
         result = (count5 >= 3'd3);
      end else begin
         result = (count3 >= 2'd2);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ hdl/lfs_req_if.sv @@
// sensor sample channel
`default_nettype none

interface lfs_req_if;
   logic valid;
   logic ready;
   logic raw_left;
   logic raw_right;

   modport source (output valid, output raw_left, output raw_right, input ready);
   modport sink   (input valid, input raw_left, input raw_right, output ready);
endinterface

`default_nettype wire

@@ hdl/lfs_rsp_if.sv @@
// wheel command channel
`default_nettype none

interface lfs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [8:0]  left_drive;
   logic signed [8:0]  right_drive;
   logic               in_search;
   logic signed [15:0] search_remaining;
   logic signed [1:0]  turn_memory;

   modport source (output valid, output left_drive, output right_drive, output in_search,
                   output search_remaining, output turn_memory, input ready);
   modport sink   (input valid, input left_drive, input right_drive, input in_search,
                   input search_remaining, input turn_memory, output ready);
endinterface

`default_nettype wire

@@ hdl/line_follower_steering_unit.sv @@
// top level of the line follower steering unit
`default_nettype none

// channel   direction  handshake     payload
// req_bus   in         valid/ready   raw_left, raw_right
// rsp_bus   out        valid/ready   left_drive, right_drive, in_search,
//                                    search_remaining, turn_memory
// csr_*     in         write enable  csr_index, csr_write_data (no read-back)
//
// an item is held in the input register, then the filter, countdown and steering
// logic run combinationally from it into the result register
// one item per cycle sustained unless rsp_bus stalls; the result register frees as taken
// a stalled result holds the pipe; req_bus.ready drops only when both stages are full
// synchronous active high reset clears histories, countdown, direction, valid flags

module line_follower_steering_unit #(
   parameter int HISTORY_DEPTH = 5
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lfs_req_if.sink                                   req_bus,
   lfs_rsp_if.source                                 rsp_bus,
   input  wire logic                                 csr_write_enable,
   input  wire logic [lfs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [lfs_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   // configuration registers
   logic [2:0]  filter_window_ff;
   logic        line_is_high_ff;
   logic [14:0] search_ticks_ff;
   logic [7:0]  search_speed_ff;
   logic [7:0]  base_speed_ff;
   logic [7:0]  turn_delta_ff;

   // input stage
   logic                req_valid_ff;
   lfs_pkg::sensor_type sample_ff;

   // steering state
   logic signed [15:0] search_count_ff, search_count_in;
   logic signed [1:0]  last_dir_ff, last_dir_in;

   // result register
   logic               rsp_valid_ff;
   logic signed [8:0]  left_drive_ff, left_drive_in;
   logic signed [8:0]  right_drive_ff, right_drive_in;
   logic               in_search_ff, in_search_in;

   logic                out_free;
   logic                advance;
   lfs_pkg::sensor_type on_line;
   logic signed [8:0]   spin;
   logic signed [8:0]   slow;
   logic [8:0]          fast;
   logic [7:0]          slow_clamped, fast_clamped;

   // result register frees when empty or taken this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance = req_valid_ff && out_free;
   assign req_bus.ready = !req_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_window_ff <= lfs_pkg::RESET_FILTER_WINDOW;
         line_is_high_ff <= lfs_pkg::RESET_LINE_IS_HIGH;
         search_ticks_ff <= lfs_pkg::RESET_SEARCH_TICKS;
         search_speed_ff <= lfs_pkg::RESET_SEARCH_SPEED;
         base_speed_ff <= lfs_pkg::RESET_BASE_SPEED;
         turn_delta_ff <= lfs_pkg::RESET_TURN_DELTA;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lfs_pkg::REG_FILTER_WINDOW: filter_window_ff <= csr_write_data[2:0];
            lfs_pkg::REG_LINE_IS_HIGH:  line_is_high_ff <= csr_write_data[0];
            lfs_pkg::REG_SEARCH_TICKS:  search_ticks_ff <= csr_write_data[14:0];
            lfs_pkg::REG_SEARCH_SPEED:  search_speed_ff <= csr_write_data[7:0];
            lfs_pkg::REG_BASE_SPEED:    base_speed_ff <= csr_write_data[7:0];
            lfs_pkg::REG_TURN_DELTA:    turn_delta_ff <= csr_write_data[7:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         sample_ff.left <= req_bus.raw_left;
         sample_ff.right <= req_bus.raw_right;
      end
   end

   lfs_filter #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_filter (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample       (sample_ff),
      .window       (filter_window_ff),
      .line_is_high (line_is_high_ff),
      .on_line      (on_line)
   );

   // steering
   always_comb begin
      spin = $signed({1'b0, search_speed_ff});
      // base minus delta clamps at zero, base plus delta at full speed
      slow = $signed({1'b0, base_speed_ff}) - $signed({1'b0, turn_delta_ff});
      fast = {1'b0, base_speed_ff} + {1'b0, turn_delta_ff};
      slow_clamped = slow[8] ? 8'd0 : slow[7:0];
      fast_clamped = fast[8] ? lfs_pkg::SPEED_MAX : fast[7:0];

      search_count_in = 16'sd0;
      last_dir_in = last_dir_ff;
      in_search_in = 1'b0;
      left_drive_in = $signed({1'b0, base_speed_ff});
      right_drive_in = $signed({1'b0, base_speed_ff});

      unique if (!on_line.left && !on_line.right) begin
         // line lost: spin toward last turn, right when unknown
         in_search_in = 1'b1;
         if (search_count_ff <= 16'sd0) begin
            search_count_in = $signed({1'b0, search_ticks_ff}) - 16'sd1;
         end else begin
            search_count_in = search_count_ff - 16'sd1;
         end
         if (last_dir_ff == lfs_pkg::DIR_LEFT) begin
            left_drive_in = spin;
            right_drive_in = -spin;
         end else begin
            left_drive_in = -spin;
            right_drive_in = spin;
         end
      end else if (on_line.left && !on_line.right) begin
         left_drive_in = $signed({1'b0, slow_clamped});
         right_drive_in = $signed({1'b0, fast_clamped});
         last_dir_in = lfs_pkg::DIR_LEFT;
      end else if (!on_line.left && on_line.right) begin
         left_drive_in = $signed({1'b0, fast_clamped});
         right_drive_in = $signed({1'b0, slow_clamped});
         last_dir_in = lfs_pkg::DIR_RIGHT;
      end else begin
         last_dir_in = lfs_pkg::DIR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_count_ff <= 16'sd0;
         last_dir_ff <= lfs_pkg::DIR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            search_count_ff <= search_count_in;
            last_dir_ff <= last_dir_in;
         end
         if (out_free) begin
            rsp_valid_ff <= advance;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         left_drive_ff <= left_drive_in;
         right_drive_ff <= right_drive_in;
         in_search_ff <= in_search_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.left_drive = left_drive_ff;
   assign rsp_bus.right_drive = right_drive_ff;
   assign rsp_bus.in_search = in_search_ff;
   // countdown and direction registers change only when a new result loads
   assign rsp_bus.search_remaining = search_count_ff;
   assign rsp_bus.turn_memory = last_dir_ff;

   a_countdown_floor: assert property (@(posedge clock) disable iff (reset)
      search_count_ff >= -16'sd1)
      else $error("search countdown below minus one");

   a_on_line_clears_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !in_search_ff |-> search_count_ff == 16'sd0
         && !left_drive_ff[8] && !right_drive_ff[8])
      else $error("on-line result with countdown or reverse drive");

   a_direction_code: assert property (@(posedge clock) disable iff (reset)
      last_dir_ff != 2'sb10)
      else $error("invalid remembered direction");

   a_spin_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && in_search_ff |-> left_drive_ff == -right_drive_ff)
      else $error("search spin wheels not opposite");

endmodule

`default_nettype wire

@@ hdl/lfs_filter.sv @@
// sensor histories, majority filter and polarity mapping
`default_nettype none

module lfs_filter #(
   parameter int HISTORY_DEPTH = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire lfs_pkg::sensor_type sample,
   input  wire logic [2:0]       window,
   input  wire logic             line_is_high,
   output lfs_pkg::sensor_type   on_line
);

   localparam int IW = $clog2(HISTORY_DEPTH);

   logic [HISTORY_DEPTH-1:0] left_hist_ff, left_hist_in;
   logic [HISTORY_DEPTH-1:0] right_hist_ff, right_hist_in;
   logic [IW-1:0]            index_ff, index_in;
   logic [2:0]               wnd;
   logic [IW:0]              index_plus;
   logic                     vote_left, vote_right;

   always_comb begin
      wnd = lfs_pkg::eff_window(window);
      left_hist_in = left_hist_ff;
      right_hist_in = right_hist_ff;
      left_hist_in[index_ff] = sample.left;
      right_hist_in[index_ff] = sample.right;
      // wrap at the window, one subtract is enough since index stays below five
      index_plus = (IW+1)'(index_ff) + (IW+1)'(1);
      if (wnd == 3'd1) begin
         index_in = '0;
      end else if (index_plus >= (IW+1)'(wnd)) begin
         index_in = IW'(index_plus - (IW+1)'(wnd));
      end else begin
         index_in = IW'(index_plus);
      end
      vote_left = lfs_pkg::majority(left_hist_in[4:0], wnd);
      vote_right = lfs_pkg::majority(right_hist_in[4:0], wnd);
      on_line.left = line_is_high ? vote_left : ~vote_left;
      on_line.right = line_is_high ? vote_right : ~vote_right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_hist_ff <= '0;
         right_hist_ff <= '0;
         index_ff <= '0;
      end else if (advance) begin
         left_hist_ff <= left_hist_in;
         right_hist_ff <= right_hist_in;
         index_ff <= index_in;
      end
   end

   a_index_in_window: assert property (@(posedge clock) disable iff (reset)
      index_ff < IW'(lfs_pkg::MAX_WINDOW))
      else $error("history index beyond largest window");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(index_ff) && $stable(left_hist_ff))
      else $error("history moved without an item");

   a_window_one_index: assert property (@(posedge clock) disable iff (reset)
      advance && lfs_pkg::eff_window(window) == 3'd1 |=> index_ff == '0)
      else $error("window one must keep index at zero");

endmodule

`default_nettype wire

@@ tb/line_follower_steering_unit_tb.sv @@
// testbench of the line follower steering unit: directed table, random phases, self-checking
`default_nettype none

module line_follower_steering_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // two register stages between an accepted sample and its command
   localparam int PIPE_LATENCY = 2;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 240;

   // one full set of the six tuning registers
   typedef struct packed {
      logic [2:0]  window;
      logic        line_high;
      logic [14:0] ticks;
      logic [7:0]  spin;
      logic [7:0]  base;
      logic [7:0]  delta;
   } tuning_type;

   // one wheel command item as it leaves the block
   typedef struct packed {
      logic signed [8:0]  left_drive;
      logic signed [8:0]  right_drive;
      logic               in_search;
      logic signed [15:0] search_remaining;
      logic signed [1:0]  turn_memory;
   } drive_cmd_type;

   // a command typed into the table replaces the predicted one
   typedef struct packed {
      logic          pinned;
      drive_cmd_type cmd;
   } pin_type;

   typedef struct packed {
      logic          retune;
      tuning_type    tune;
      logic          left;
      logic          right;
      logic          pinned;
      drive_cmd_type cmd;
   } directed_row_type;

   localparam tuning_type RESET_TUNING = '{lfs_pkg::RESET_FILTER_WINDOW,
      lfs_pkg::RESET_LINE_IS_HIGH, lfs_pkg::RESET_SEARCH_TICKS, lfs_pkg::RESET_SEARCH_SPEED,
      lfs_pkg::RESET_BASE_SPEED, lfs_pkg::RESET_TURN_DELTA};
   localparam tuning_type KEEP = '0;
   // window one, zero reload, every speed at full scale
   localparam tuning_type HARD_TURN = '{3'd1, 1'b1, 15'd0, 8'd255, 8'd255, 8'd255};
   // window five, inverted sensors, longest countdown, no spin and no base speed
   localparam tuning_type WIDE_INV = '{3'd5, 1'b0, 15'd32767, 8'd0, 8'd0, 8'd255};
   // window seven falls back to three, reload of one
   localparam tuning_type ODD_WINDOW = '{3'd7, 1'b1, 15'd1, 8'd1, 8'd128, 8'd0};
   localparam drive_cmd_type NO_CMD = '0;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [lfs_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [lfs_pkg::CSR_DATA_WIDTH-1:0] csr_write_data;

   lfs_req_if req_bus ();
   lfs_rsp_if rsp_bus ();

   line_follower_steering_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state, mirrors the block after reset
   tuning_type        tuning = RESET_TUNING;
   logic [4:0]        hist_l = '0;
   logic [4:0]        hist_r = '0;
   logic [2:0]        hist_pos = '0;
   int                countdown = 0;
   logic signed [1:0] memory = lfs_pkg::DIR_NONE;

   drive_cmd_type expected_cmds [$];
   pin_type       pinned_cmds [$];
   int            mismatches = 0;
   int            idle_pct = 9;
   int            stall_pct = 9;

   drive_cmd_type got_cmd;
   drive_cmd_type want_cmd;
   drive_cmd_type fresh_cmd;
   pin_type       pin;

   // directed table: reset tuning first, then three fixed tunings at the extremes
   directed_row_type plan [0:24] = '{
      // reset tuning: lost line spins right from an unknown direction
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b1, '{-9'sd120, 9'sd120, 1'b1, 16'sd49, lfs_pkg::DIR_NONE}},
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b1, '{-9'sd120, 9'sd120, 1'b1, 16'sd48, lfs_pkg::DIR_NONE}},
      '{1'b0, KEEP, 1'b1, 1'b0, 1'b0, NO_CMD},
      // second vote of three flips the left side on
      '{1'b0, KEEP, 1'b1, 1'b0, 1'b1, '{9'sd90, 9'sd210, 1'b0, 16'sd0, lfs_pkg::DIR_LEFT}},
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b0, NO_CMD},
      // search now spins toward the remembered left turn
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b0, NO_CMD},
      // window one with stale entries and the index left over from window three
      '{1'b1, HARD_TURN, 1'b0, 1'b0, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b0, NO_CMD},
      // turns clamp at both ends
      '{1'b0, KEEP, 1'b1, 1'b0, 1'b1, '{9'sd0, 9'sd255, 1'b0, 16'sd0, lfs_pkg::DIR_LEFT}},
      '{1'b0, KEEP, 1'b0, 1'b1, 1'b1, '{9'sd255, 9'sd0, 1'b0, 16'sd0, lfs_pkg::DIR_RIGHT}},
      '{1'b0, KEEP, 1'b1, 1'b1, 1'b1, '{9'sd255, 9'sd255, 1'b0, 16'sd0, lfs_pkg::DIR_NONE}},
      // zero reload leaves the countdown at minus one
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b1, '{-9'sd255, 9'sd255, 1'b1, -16'sd1, lfs_pkg::DIR_NONE}},
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b1, '{-9'sd255, 9'sd255, 1'b1, -16'sd1, lfs_pkg::DIR_NONE}},
      // window five, inverted polarity
      '{1'b1, WIDE_INV, 1'b1, 1'b1, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b1, 1'b1, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b1, 1'b1, 1'b1, '{9'sd0, 9'sd0, 1'b1, 16'sd32766, lfs_pkg::DIR_NONE}},
      '{1'b0, KEEP, 1'b0, 1'b1, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b0, 1'b1, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b0, 1'b1, 1'b1, '{9'sd0, 9'sd255, 1'b0, 16'sd0, lfs_pkg::DIR_LEFT}},
      // out of range window acts as three
      '{1'b1, ODD_WINDOW, 1'b0, 1'b0, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b0, 1'b0, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b1, 1'b1, 1'b0, NO_CMD},
      '{1'b0, KEEP, 1'b1, 1'b1, 1'b1, '{9'sd128, 9'sd128, 1'b0, 16'sd0, lfs_pkg::DIR_NONE}},
      '{1'b0, KEEP, 1'b0, 1'b1, 1'b0, NO_CMD}
   };

   // free running clock, 10 ns period
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // steering predictor: filter one sample pair and work out the wheel command
   function automatic drive_cmd_type steer_sample(input logic raw_l, input logic raw_r);
      int            span;
      int            votes_l;
      int            votes_r;
      int            k;
      int            heading;
      int            spd_l;
      int            spd_r;
      logic          seen_l;
      logic          seen_r;
      drive_cmd_type cmd;
      span = (tuning.window == 3'd1 || tuning.window == 3'd5) ? int'(tuning.window) : 3;
      // write at the kept index, then wrap at the current window
      hist_l[hist_pos] = raw_l;
      hist_r[hist_pos] = raw_r;
      hist_pos = 3'((int'(hist_pos) + 1) % span);
      votes_l = 0;
      votes_r = 0;
      for (k = 0; k < span; k++) begin
         votes_l += int'(hist_l[k]);
         votes_r += int'(hist_r[k]);
      end
      seen_l = (votes_l > span / 2) ? tuning.line_high : !tuning.line_high;
      seen_r = (votes_r > span / 2) ? tuning.line_high : !tuning.line_high;
      cmd = '0;
      if (!seen_l && !seen_r) begin
         // spin in place; right when no turn is remembered
         heading = (memory == lfs_pkg::DIR_NONE) ? 1 : int'(memory);
         if (countdown <= 0) begin
            countdown = int'(tuning.ticks);
         end
         countdown--;
         spd_l = -int'(tuning.spin) * heading;
         spd_r = int'(tuning.spin) * heading;
         cmd.in_search = 1'b1;
      end else begin
         countdown = 0;
         spd_l = int'(tuning.base);
         spd_r = int'(tuning.base);
         if (seen_l && !seen_r) begin
            spd_l = int'(tuning.base) - int'(tuning.delta);
            spd_r = int'(tuning.base) + int'(tuning.delta);
            memory = lfs_pkg::DIR_LEFT;
         end else if (!seen_l && seen_r) begin
            spd_l = int'(tuning.base) + int'(tuning.delta);
            spd_r = int'(tuning.base) - int'(tuning.delta);
            memory = lfs_pkg::DIR_RIGHT;
         end else begin
            memory = lfs_pkg::DIR_NONE;
         end
         if (spd_l < 0) spd_l = 0;
         if (spd_l > int'(lfs_pkg::SPEED_MAX)) spd_l = int'(lfs_pkg::SPEED_MAX);
         if (spd_r < 0) spd_r = 0;
         if (spd_r > int'(lfs_pkg::SPEED_MAX)) spd_r = int'(lfs_pkg::SPEED_MAX);
      end
      cmd.left_drive = 9'(spd_l);
      cmd.right_drive = 9'(spd_r);
      cmd.search_remaining = 16'(countdown);
      cmd.turn_memory = memory;
      return cmd;
   endfunction

   function automatic void check_field(input string field, input logic signed [15:0] want,
                                       input logic signed [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // scoreboard: check the command taken at this edge, then predict the sample taken
   // at this edge; the input and result registers keep a fresh item away from the check
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_cmd = '{rsp_bus.left_drive, rsp_bus.right_drive, rsp_bus.in_search,
                        rsp_bus.search_remaining, rsp_bus.turn_memory};
            if (expected_cmds.size() == 0) begin
               $error("wheel command item with none expected");
               mismatches++;
            end else begin
               want_cmd = expected_cmds.pop_front();
               check_field("left_drive", want_cmd.left_drive, got_cmd.left_drive);
               check_field("right_drive", want_cmd.right_drive, got_cmd.right_drive);
               check_field("in_search", want_cmd.in_search, got_cmd.in_search);
               check_field("search_remaining", want_cmd.search_remaining,
                           got_cmd.search_remaining);
               check_field("turn_memory", want_cmd.turn_memory, got_cmd.turn_memory);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            pin = pinned_cmds.pop_front();
            fresh_cmd = steer_sample(req_bus.raw_left, req_bus.raw_right);
            expected_cmds.push_back(pin.pinned ? pin.cmd : fresh_cmd);
         end
      end
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // hold one sample until it is taken, with random gaps in front
   task automatic send_sample(input logic raw_l, input logic raw_r, input logic pinned,
                              input drive_cmd_type cmd);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      pinned_cmds.push_back('{pinned, cmd});
      req_bus.valid <= 1'b1;
      req_bus.raw_left <= raw_l;
      req_bus.raw_right <= raw_r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop sending and let every outstanding command come back
   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lfs_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [lfs_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // all six registers back to back, only while the block is idle
   task automatic program_settings(input tuning_type t);
      write_reg(lfs_pkg::REG_FILTER_WINDOW, lfs_pkg::CSR_DATA_WIDTH'(t.window));
      write_reg(lfs_pkg::REG_LINE_IS_HIGH, lfs_pkg::CSR_DATA_WIDTH'(t.line_high));
      write_reg(lfs_pkg::REG_SEARCH_TICKS, lfs_pkg::CSR_DATA_WIDTH'(t.ticks));
      write_reg(lfs_pkg::REG_SEARCH_SPEED, lfs_pkg::CSR_DATA_WIDTH'(t.spin));
      write_reg(lfs_pkg::REG_BASE_SPEED, lfs_pkg::CSR_DATA_WIDTH'(t.base));
      write_reg(lfs_pkg::REG_TURN_DELTA, lfs_pkg::CSR_DATA_WIDTH'(t.delta));
      csr_write_enable <= 1'b0;
      tuning = t;
   endtask

   function automatic logic [7:0] pick_speed();
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return lfs_pkg::SPEED_MAX;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // valid windows most of the time, short reloads often so the countdown wraps
   function automatic tuning_type random_tuning();
      tuning_type t;
      if ($urandom_range(0, 9) < 6) begin
         t.window = 3'(2 * $urandom_range(0, 2) + 1);
      end else begin
         t.window = 3'($urandom_range(0, 7));
      end
      t.line_high = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: t.ticks = 15'd0;
         1: t.ticks = 15'd32767;
         2, 3: t.ticks = 15'($urandom_range(1, 6));
         4: t.ticks = 15'($urandom_range(7, 100));
         default: t.ticks = 15'($urandom_range(0, 32767));
      endcase
      t.spin = pick_speed();
      t.base = pick_speed();
      t.delta = pick_speed();
      return t;
   endfunction

   // runs of one sensor pattern so the vote settles, sprinkled with noisy samples
   task automatic run_random_phase(input int count);
      int         sent;
      int         run;
      int         k;
      logic [1:0] pattern;
      logic [1:0] sample;
      sent = 0;
      while (sent < count) begin
         pattern = 2'($urandom_range(0, 3));
         run = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 10);
         for (k = 0; k < run && sent < count; k++) begin
            sample = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : pattern;
            send_sample(sample[1], sample[0], 1'b0, NO_CMD);
            sent++;
         end
      end
   endtask

   initial begin
      int i;
      int phase;
      tuning_type t;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.raw_left = 1'b0;
      req_bus.raw_right = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < 25; i++) begin
         if (plan[i].retune) begin
            wait_for_quiet();
            program_settings(plan[i].tune);
         end
         send_sample(plan[i].left, plan[i].right, plan[i].pinned, plan[i].cmd);
      end

      // random phases; each boundary drains the pipe before retuning
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_quiet();
         case (phase)
            0: t = '{3'd7, 1'b1, 15'd32767, 8'd255, 8'd255, 8'd255};
            1: t = '{3'd0, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0};
            default: t = random_tuning();
         endcase
         program_settings(t);
         // one phase runs with both sides streaming back to back
         idle_pct = (phase == 3) ? 0 : 9;
         stall_pct = (phase == 3) ? 0 : 9;
         run_random_phase(PHASE_ITEMS);
      end

      wait_for_quiet();
      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("line_follower_steering_unit_tb OK");
      end else begin
         $display("line_follower_steering_unit_tb NOT OK");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("line_follower_steering_unit_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

@@ line_follower_steering_unit.f @@
hdl/lfs_pkg.sv
hdl/lfs_req_if.sv
hdl/lfs_rsp_if.sv
hdl/lfs_filter.sv
hdl/line_follower_steering_unit.sv
tb/line_follower_steering_unit_tb.sv
